/* hw/rtl/cpcr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cpcr_pkg;

  localparam int NB      = 28;
  localparam int WB      = 28;
  localparam int ROOT_W  = 32;
  localparam int RAD_W   = 63;
  localparam int SQ_W    = 64;
  localparam int DIV_NW  = 61;
  localparam int DIV_DW  = 33;
  localparam int DIV_QW  = 30;
  localparam int DIV_CW  = DIV_DW + DIV_QW;
  localparam int ACC_W   = 72;

  localparam logic [1:0] FLAGS_BOTH = 2'b11;
  localparam logic [1:0] FLAGS_NONE = 2'b00;

  localparam logic [DIV_QW-1:0] QONE = DIV_QW'(1) << NB;
  localparam logic [DIV_QW-1:0] WONE = DIV_QW'(1) << WB;
  localparam logic signed [ACC_W-1:0] HALF_N  = ACC_W'(1) << (NB - 1);
  localparam logic signed [ACC_W-1:0] HALF_N1 = ACC_W'(1) << NB;
  localparam logic signed [ACC_W-1:0] SAT_MAX = 72'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -72'sd2147483648;

  typedef struct packed {
    logic signed [31:0] pos_ax;
    logic signed [31:0] pos_ay;
    logic signed [31:0] vel_ax;
    logic signed [31:0] vel_ay;
    logic signed [31:0] pos_bx;
    logic signed [31:0] pos_by;
    logic signed [31:0] vel_bx;
    logic signed [31:0] vel_by;
    logic [31:0]        radius_sum;
    logic [31:0]        mass_a;
    logic [31:0]        mass_b;
    logic [1:0]         fixed_flags;
  } cpcr_pair_t;

  typedef struct packed {
    logic signed [31:0] new_ax;
    logic signed [31:0] new_ay;
    logic signed [31:0] new_vax;
    logic signed [31:0] new_vay;
    logic signed [31:0] new_bx;
    logic signed [31:0] new_by;
    logic signed [31:0] new_vbx;
    logic signed [31:0] new_vby;
    logic               coincident;
  } cpcr_res_t;

  typedef struct packed {
    cpcr_pair_t         pair;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               s;
  } cpcr_geo_t;

  typedef struct packed {
    cpcr_geo_t   geo;
    logic [32:0] d;
    logic        mzero;
  } cpcr_sep_t;

  // round half away from zero, by NB or NB+1 bits
  function automatic logic signed [ACC_W-1:0] rshr(input logic signed [ACC_W-1:0] x,
                                                   input logic wide);
    logic signed [ACC_W-1:0] y;
    y = x + (wide ? HALF_N1 : HALF_N) - ACC_W'(x[ACC_W-1]);
    return wide ? (y >>> (NB + 1)) : (y >>> NB);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    y = x;
    if (x > SAT_MAX) y = SAT_MAX;
    if (x < SAT_MIN) y = SAT_MIN;
    return y[31:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/cpcr_delay.sv */
`timescale 1ns / 1ps
`default_nettype none
module cpcr_delay #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             head_valid,
  input  logic [WIDTH-1:0] head,
  output logic             tail_valid,
  output logic [WIDTH-1:0] tail
);

  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] dat [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld[0] <= head_valid;
      for (int i = 1; i < DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat[0] <= head;
      for (int i = 1; i < DEPTH; i++) begin
        dat[i] <= dat[i-1];
      end
    end
  end

  assign tail_valid = vld[DEPTH-1];
  assign tail       = dat[DEPTH-1];

endmodule
`default_nettype wire

/* hw/rtl/cpcr_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module cpcr_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [cpcr_pkg::RAD_W-1:0]  rad,
  output logic [cpcr_pkg::ROOT_W-1:0] root
);
  import cpcr_pkg::*;

  logic [SQ_W-1:0] rem_q [ROOT_W];
  logic [SQ_W-1:0] acc_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam logic [SQ_W-1:0] BITK = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [SQ_W-1:0] rem_cur;
    logic [SQ_W-1:0] acc_cur;
    logic [SQ_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_cur = SQ_W'(rad);
      assign acc_cur = '0;
    end else begin : g_rest
      assign rem_cur = rem_q[k-1];
      assign acc_cur = acc_q[k-1];
    end

    assign trial = acc_cur + BITK;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_cur >= trial) begin
          rem_q[k] <= rem_cur - trial;
          acc_q[k] <= (acc_cur >> 1) + BITK;
        end else begin
          rem_q[k] <= rem_cur;
          acc_q[k] <= acc_cur >> 1;
        end
      end
    end
  end

  assign root = acc_q[ROOT_W-1][ROOT_W-1:0];

endmodule
`default_nettype wire

/* hw/rtl/cpcr_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module cpcr_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [cpcr_pkg::DIV_NW-1:0] num,
  input  logic [cpcr_pkg::DIV_DW-1:0] den,
  output logic [cpcr_pkg::DIV_QW-1:0] quo
);
  import cpcr_pkg::*;

  logic [DIV_CW-1:0] rem_q [DIV_QW];
  logic [DIV_DW-1:0] den_q [DIV_QW];
  logic [DIV_QW-1:0] quo_q [DIV_QW];

  for (genvar k = 0; k < DIV_QW; k++) begin : g_step
    localparam int SH = DIV_QW - 1 - k;
    logic [DIV_CW-1:0] rem_cur;
    logic [DIV_DW-1:0] den_cur;
    logic [DIV_QW-1:0] quo_cur;
    logic [DIV_CW-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_cur = DIV_CW'(num);
      assign den_cur = den;
      assign quo_cur = '0;
    end else begin : g_rest
      assign rem_cur = rem_q[k-1];
      assign den_cur = den_q[k-1];
      assign quo_cur = quo_q[k-1];
    end

    assign trial = DIV_CW'(den_cur) << SH;

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k] <= den_cur;
        if (rem_cur >= trial) begin
          rem_q[k] <= rem_cur - trial;
          quo_q[k] <= quo_cur | (DIV_QW'(1) << SH);
        end else begin
          rem_q[k] <= rem_cur;
          quo_q[k] <= quo_cur;
        end
      end
    end
  end

  assign quo = quo_q[DIV_QW-1];

endmodule
`default_nettype wire

/* hw/rtl/circle_pair_collision_resolve_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted pair word flows through the difference, square, root, divider and exchange stages to its result on res.
// Throughput: one pair word per cycle unless res is stalled; set by the per-cycle pipeline advance.
// The 32-stage square root and the 30-stage dividers dominate the depth.
// res_stall freezes the whole pipeline; bubbles advance while res is free.
// Synchronous reset clears all valid bits; payload registers are not reset.
module circle_pair_collision_resolve_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pair_valid,
  output logic                 pair_stall,
  input  cpcr_pkg::cpcr_pair_t pair,
  output logic                 res_valid,
  input  logic                 res_stall,
  output cpcr_pkg::cpcr_res_t  res
);
  import cpcr_pkg::*;

  localparam logic signed [DIV_QW-1:0] NORM_ONE = DIV_QW'(1) << NB;
  localparam logic [DIV_QW:0]          WSUM_MAX = (DIV_QW + 1)'(1) << (WB + 1);

  logic en;
  assign en         = !(res_valid && res_stall);
  assign pair_stall = !en;

  // difference of centers
  logic               v1;
  cpcr_pair_t         p1;
  logic signed [32:0] dx1, dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= pair;
      dx1 <= 33'(pair.pos_bx) - 33'(pair.pos_ax);
      dy1 <= 33'(pair.pos_by) - 33'(pair.pos_ay);
    end
  end

  // squares
  logic [32:0] mx1, my1;
  logic        s1;
  logic [30:0] ex1, ey1;

  always_comb begin
    mx1 = dx1[32] ? 33'(-dx1) : 33'(dx1);
    my1 = dy1[32] ? 33'(-dy1) : 33'(dy1);
    s1  = (mx1[32:31] != 2'b00) || (my1[32:31] != 2'b00);
    ex1 = s1 ? mx1[31:1] : mx1[30:0];
    ey1 = s1 ? my1[31:1] : my1[30:0];
  end

  logic        v2;
  cpcr_geo_t   geo2;
  logic [61:0] exsq2, eysq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo2.pair <= p1;
      geo2.dx   <= dx1;
      geo2.dy   <= dy1;
      geo2.s    <= s1;
      exsq2     <= ex1 * ex1;
      eysq2     <= ey1 * ey1;
    end
  end

  logic             v3;
  cpcr_geo_t        geo3;
  logic [RAD_W-1:0] rad3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo3 <= geo2;
      rad3 <= RAD_W'(exsq2) + RAD_W'(eysq2);
    end
  end

  // distance
  logic [ROOT_W-1:0] root35;
  logic              v35;
  cpcr_geo_t         geo35;

  cpcr_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad3),
    .root (root35)
  );

  cpcr_delay #(
    .DEPTH (ROOT_W),
    .WIDTH ($bits(cpcr_geo_t))
  ) u_geo_dly (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .head_valid (v3),
    .head       (geo3),
    .tail_valid (v35),
    .tail       (geo35)
  );

  logic [32:0]       d35;
  logic [32:0]       mxa35, mya35;
  logic [DIV_NW-1:0] numx35, numy35, numa35, numb35;
  logic [32:0]       msum35;

  always_comb begin
    d35    = {1'b0, root35} << geo35.s;
    mxa35  = geo35.dx[32] ? 33'(-geo35.dx) : 33'(geo35.dx);
    mya35  = geo35.dy[32] ? 33'(-geo35.dy) : 33'(geo35.dy);
    numx35 = DIV_NW'({mxa35[31:0], {NB{1'b0}}}) + DIV_NW'(d35[32:1]);
    numy35 = DIV_NW'({mya35[31:0], {NB{1'b0}}}) + DIV_NW'(d35[32:1]);
    numa35 = DIV_NW'({geo35.pair.mass_b, {(WB + 1){1'b0}}});
    numb35 = DIV_NW'({geo35.pair.mass_a, {(WB + 1){1'b0}}});
    msum35 = 33'(geo35.pair.mass_a) + 33'(geo35.pair.mass_b);
  end

  logic              v36;
  cpcr_sep_t         sep36;
  logic [DIV_NW-1:0] numx36, numy36, numa36, numb36;
  logic [32:0]       msum36;

  always_ff @(posedge clk) begin
    if (rst) begin
      v36 <= 1'b0;
    end else if (en) begin
      v36 <= v35;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sep36.geo   <= geo35;
      sep36.d     <= d35;
      sep36.mzero <= (msum35 == '0);
      numx36      <= numx35;
      numy36      <= numy35;
      numa36      <= numa35;
      numb36      <= numb35;
      msum36      <= msum35;
    end
  end

  // unit normal and mass weights
  logic [DIV_QW-1:0] qx66, qy66, qa66, qb66;
  logic              v66;
  cpcr_sep_t         sep66;

  cpcr_div u_div_nx (.clk(clk), .en(en), .num(numx36), .den(sep36.d), .quo(qx66));
  cpcr_div u_div_ny (.clk(clk), .en(en), .num(numy36), .den(sep36.d), .quo(qy66));
  cpcr_div u_div_wa (.clk(clk), .en(en), .num(numa36), .den(msum36),  .quo(qa66));
  cpcr_div u_div_wb (.clk(clk), .en(en), .num(numb36), .den(msum36),  .quo(qb66));

  cpcr_delay #(
    .DEPTH (DIV_QW),
    .WIDTH ($bits(cpcr_sep_t))
  ) u_sep_dly (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .head_valid (v36),
    .head       (sep36),
    .tail_valid (v66),
    .tail       (sep66)
  );

  logic [DIV_QW-1:0] qcx66, qcy66;

  always_comb begin
    qcx66 = (qx66 > QONE) ? QONE : qx66;
    qcy66 = (qy66 > QONE) ? QONE : qy66;
  end

  logic                     v67;
  cpcr_pair_t               p67;
  logic                     coin67;
  logic signed [DIV_QW-1:0] nx67, ny67;
  logic [DIV_QW-1:0]        wa67, wb67;
  logic signed [33:0]       gap67;

  always_ff @(posedge clk) begin
    if (rst) begin
      v67 <= 1'b0;
    end else if (en) begin
      v67 <= v66;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p67    <= sep66.geo.pair;
      coin67 <= (sep66.d == '0);
      nx67   <= sep66.geo.dx[32] ? -$signed(qcx66) : $signed(qcx66);
      ny67   <= sep66.geo.dy[32] ? -$signed(qcy66) : $signed(qcy66);
      wa67   <= sep66.mzero ? WONE : qa66;
      wb67   <= sep66.mzero ? WONE : qb66;
      gap67  <= $signed(34'(sep66.d)) - $signed(34'(sep66.geo.pair.radius_sum));
    end
  end

  // projections
  logic                     v68;
  cpcr_pair_t               p68;
  logic                     coin68;
  logic signed [DIV_QW-1:0] nx68, ny68;
  logic [DIV_QW-1:0]        wa68, wb68;
  logic signed [63:0]       gnx68, gny68;
  logic signed [61:0]       pa1_68, pa2_68, pb1_68, pb2_68;
  logic signed [61:0]       ta1_68, ta2_68, tb1_68, tb2_68;

  always_ff @(posedge clk) begin
    if (rst) begin
      v68 <= 1'b0;
    end else if (en) begin
      v68 <= v67;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p68    <= p67;
      coin68 <= coin67;
      nx68   <= nx67;
      ny68   <= ny67;
      wa68   <= wa67;
      wb68   <= wb67;
      gnx68  <= gap67 * nx67;
      gny68  <= gap67 * ny67;
      pa1_68 <= $signed(p67.vel_ax) * nx67;
      pa2_68 <= $signed(p67.vel_ay) * ny67;
      pb1_68 <= $signed(p67.vel_bx) * nx67;
      pb2_68 <= $signed(p67.vel_by) * ny67;
      ta1_68 <= $signed(p67.vel_ay) * nx67;
      ta2_68 <= $signed(p67.vel_ax) * ny67;
      tb1_68 <= $signed(p67.vel_by) * nx67;
      tb2_68 <= $signed(p67.vel_bx) * ny67;
    end
  end

  logic                     v69;
  cpcr_pair_t               p69;
  logic                     coin69;
  logic signed [DIV_QW-1:0] nx69, ny69;
  logic [DIV_QW-1:0]        wa69, wb69;
  logic signed [35:0]       cx69, cy69, pa69, pb69, dta69, dtb69;
  logic                     wide68;

  assign wide68 = (p68.fixed_flags == FLAGS_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      v69 <= 1'b0;
    end else if (en) begin
      v69 <= v68;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p69    <= p68;
      coin69 <= coin68;
      nx69   <= nx68;
      ny69   <= ny68;
      wa69   <= wa68;
      wb69   <= wb68;
      cx69   <= 36'(rshr(ACC_W'(gnx68), wide68));
      cy69   <= 36'(rshr(ACC_W'(gny68), wide68));
      pa69   <= 36'(rshr(ACC_W'(pa1_68) + ACC_W'(pa2_68), 1'b0));
      pb69   <= 36'(rshr(ACC_W'(pb1_68) + ACC_W'(pb2_68), 1'b0));
      dta69  <= 36'(rshr(ACC_W'(ta1_68) - ACC_W'(ta2_68), 1'b0));
      dtb69  <= 36'(rshr(ACC_W'(tb1_68) - ACC_W'(tb2_68), 1'b0));
    end
  end

  // normal exchange
  logic                     v70;
  cpcr_pair_t               p70;
  logic                     coin70;
  logic signed [DIV_QW-1:0] nx70, ny70;
  logic signed [35:0]       cx70, cy70, pa70, pb70, dta70, dtb70;
  logic signed [67:0]       wpa70, wpb70;

  always_ff @(posedge clk) begin
    if (rst) begin
      v70 <= 1'b0;
    end else if (en) begin
      v70 <= v69;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p70    <= p69;
      coin70 <= coin69;
      nx70   <= nx69;
      ny70   <= ny69;
      cx70   <= cx69;
      cy70   <= cy69;
      pa70   <= pa69;
      pb70   <= pb69;
      dta70  <= dta69;
      dtb70  <= dtb69;
      wpa70  <= $signed({1'b0, wa69}) * (37'(pb69) - 37'(pa69));
      wpb70  <= $signed({1'b0, wb69}) * (37'(pa69) - 37'(pb69));
    end
  end

  logic                     v71;
  cpcr_pair_t               p71;
  logic                     coin71;
  logic signed [DIV_QW-1:0] nx71, ny71;
  logic signed [35:0]       cx71, cy71, dta71, dtb71;
  logic signed [37:0]       qa71, qb71;

  always_ff @(posedge clk) begin
    if (rst) begin
      v71 <= 1'b0;
    end else if (en) begin
      v71 <= v70;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p71    <= p70;
      coin71 <= coin70;
      nx71   <= nx70;
      ny71   <= ny70;
      cx71   <= cx70;
      cy71   <= cy70;
      dta71  <= dta70;
      dtb71  <= dtb70;
      qa71   <= 38'(pa70) + 38'(rshr(ACC_W'(wpa70), 1'b0));
      qb71   <= 38'(pb70) + 38'(rshr(ACC_W'(wpb70), 1'b0));
    end
  end

  // rebuild velocities
  logic               v72;
  cpcr_pair_t         p72;
  logic               coin72;
  logic signed [35:0] cx72, cy72;
  logic signed [67:0] aqn72, aqt72, adn72, adt72;
  logic signed [67:0] bqn72, bqt72, bdn72, bdt72;

  always_ff @(posedge clk) begin
    if (rst) begin
      v72 <= 1'b0;
    end else if (en) begin
      v72 <= v71;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p72    <= p71;
      coin72 <= coin71;
      cx72   <= cx71;
      cy72   <= cy71;
      aqn72  <= nx71 * qa71;
      aqt72  <= ny71 * qa71;
      adn72  <= nx71 * dta71;
      adt72  <= ny71 * dta71;
      bqn72  <= nx71 * qb71;
      bqt72  <= ny71 * qb71;
      bdn72  <= nx71 * dtb71;
      bdt72  <= ny71 * dtb71;
    end
  end

  cpcr_res_t res_next;
  logic      hold_a, hold_b;

  always_comb begin
    hold_a = coin72 || (p72.fixed_flags == FLAGS_BOTH) || p72.fixed_flags[0];
    hold_b = coin72 || (p72.fixed_flags == FLAGS_BOTH) || p72.fixed_flags[1];
    res_next.coincident = coin72;
    if (hold_a) begin
      res_next.new_ax  = p72.pos_ax;
      res_next.new_ay  = p72.pos_ay;
      res_next.new_vax = p72.vel_ax;
      res_next.new_vay = p72.vel_ay;
    end else begin
      res_next.new_ax  = sat32(ACC_W'(p72.pos_ax) + ACC_W'(cx72));
      res_next.new_ay  = sat32(ACC_W'(p72.pos_ay) + ACC_W'(cy72));
      res_next.new_vax = sat32(rshr(ACC_W'(aqn72) - ACC_W'(adt72), 1'b0));
      res_next.new_vay = sat32(rshr(ACC_W'(adn72) + ACC_W'(aqt72), 1'b0));
    end
    if (hold_b) begin
      res_next.new_bx  = p72.pos_bx;
      res_next.new_by  = p72.pos_by;
      res_next.new_vbx = p72.vel_bx;
      res_next.new_vby = p72.vel_by;
    end else begin
      res_next.new_bx  = sat32(ACC_W'(p72.pos_bx) - ACC_W'(cx72));
      res_next.new_by  = sat32(ACC_W'(p72.pos_by) - ACC_W'(cy72));
      res_next.new_vbx = sat32(rshr(ACC_W'(bqn72) - ACC_W'(bdt72), 1'b0));
      res_next.new_vby = sat32(rshr(ACC_W'(bdn72) + ACC_W'(bqt72), 1'b0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= v72;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  a_coin_match : assert property (@(posedge clk) disable iff (rst)
    v36 |-> ((sep36.d == '0) == ((sep36.geo.dx == '0) && (sep36.geo.dy == '0))))
    else $error("distance and center difference disagree on coincidence");

  a_norm_range : assert property (@(posedge clk) disable iff (rst)
    v67 && !coin67 |-> (nx67 <= NORM_ONE) && (nx67 >= -NORM_ONE)
                       && (ny67 <= NORM_ONE) && (ny67 >= -NORM_ONE))
    else $error("normal component beyond unit");

  a_weight_sum : assert property (@(posedge clk) disable iff (rst)
    v66 && !sep66.mzero |-> ((DIV_QW + 1)'(qa66) + (DIV_QW + 1)'(qb66)) <= WSUM_MAX)
    else $error("mass weights exceed two");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    !en && v72 |=> v72 && $stable(cx72) && $stable(cy72))
    else $error("last stage moved while output stalled");

endmodule
`default_nettype wire

/* sim/circle_pair_collision_resolve_core_test.sv */
`timescale 1ns / 1ps
module circle_pair_collision_resolve_core_test;
  import cpcr_pkg::*;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    cpcr_pair_t pair;
    bit         typed;
    cpcr_res_t  want;
  } pair_row_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 850;

  logic       clk;
  logic       rst;
  logic       pair_valid;
  logic       pair_stall;
  cpcr_pair_t pair;
  logic       res_valid;
  logic       res_stall;
  cpcr_res_t  res;

  cpcr_res_t  pending_results[$];
  int         failures;
  int         idle_cycles;
  int         send_pct;
  int         recv_pct;
  bit         long_hold;

  circle_pair_collision_resolve_core DUT (
    .clk(clk),
    .rst(rst),
    .pair_valid(pair_valid),
    .pair_stall(pair_stall),
    .pair(pair),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic wide_t magnitude(input wide_t x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic wide_t round_shift(input wide_t x, input int n);
    wide_t m;
    m = (magnitude(x) + (wide_t'(1) <<< (n - 1))) >>> n;
    return (x < 0) ? -m : m;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic wide_t unit_comp(input wide_t c, input wide_t d);
    wide_t q;
    q = ((magnitude(c) <<< NB) + d / 2) / d;
    if (q > (wide_t'(1) <<< NB)) q = wide_t'(1) <<< NB;
    return (c < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] clamp32(input wide_t x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic void rotate_velocity(input wide_t vx, input wide_t vy, input wide_t nx,
                                          input wide_t ny, input wide_t p, output wide_t ox,
                                          output wide_t oy);
    wide_t tang;
    tang = round_shift(vx * (-ny) + vy * nx, NB);
    ox = round_shift((-ny) * tang + nx * p, NB);
    oy = round_shift(nx * tang + ny * p, NB);
  endfunction

  function automatic cpcr_res_t passthrough(input cpcr_pair_t p, input logic coin);
    cpcr_res_t o;
    o.new_ax = p.pos_ax;
    o.new_ay = p.pos_ay;
    o.new_vax = p.vel_ax;
    o.new_vay = p.vel_ay;
    o.new_bx = p.pos_bx;
    o.new_by = p.pos_by;
    o.new_vbx = p.vel_bx;
    o.new_vby = p.vel_by;
    o.coincident = coin;
    return o;
  endfunction

  function automatic cpcr_res_t resolve_pair(input cpcr_pair_t p);
    wide_t v[8];
    wide_t r[8];
    wide_t dx, dy, d, nx, ny, gap, cx, cy, msum, wa, wb, pa, pb, qa, qb;
    logic [63:0] ex, ey;
    bit fa, fb;
    int sh, s;
    cpcr_res_t o;
    v[0] = p.pos_ax; v[1] = p.pos_ay; v[2] = p.vel_ax; v[3] = p.vel_ay;
    v[4] = p.pos_bx; v[5] = p.pos_by; v[6] = p.vel_bx; v[7] = p.vel_by;
    r = v;
    dx = v[4] - v[0];
    dy = v[5] - v[1];
    s = ((magnitude(dx) >>> 31) != 0 || (magnitude(dy) >>> 31) != 0) ? 1 : 0;
    ex = 64'(magnitude(dx) >>> s);
    ey = 64'(magnitude(dy) >>> s);
    d = wide_t'(floor_sqrt(ex * ex + ey * ey)) <<< s;
    if (d == 0) return passthrough(p, 1'b1);
    if (p.fixed_flags == FLAGS_BOTH) return passthrough(p, 1'b0);
    fa = p.fixed_flags[0];
    fb = p.fixed_flags[1];
    nx = unit_comp(dx, d);
    ny = unit_comp(dy, d);
    gap = d - wide_t'(p.radius_sum);
    sh = (fa || fb) ? NB : NB + 1;
    cx = round_shift(gap * nx, sh);
    cy = round_shift(gap * ny, sh);
    msum = wide_t'(p.mass_a) + wide_t'(p.mass_b);
    if (msum == 0) begin
      wa = wide_t'(1) <<< WB;
      wb = wa;
    end else begin
      wa = (wide_t'(p.mass_b) <<< (WB + 1)) / msum;
      wb = (wide_t'(p.mass_a) <<< (WB + 1)) / msum;
    end
    pa = round_shift(v[2] * nx + v[3] * ny, NB);
    pb = round_shift(v[6] * nx + v[7] * ny, NB);
    qa = pa + round_shift(wa * (pb - pa), WB);
    qb = pb + round_shift(wb * (pa - pb), WB);
    if (!fa) begin
      r[0] = v[0] + cx;
      r[1] = v[1] + cy;
      rotate_velocity(v[2], v[3], nx, ny, qa, r[2], r[3]);
    end
    if (!fb) begin
      r[4] = v[4] - cx;
      r[5] = v[5] - cy;
      rotate_velocity(v[6], v[7], nx, ny, qb, r[6], r[7]);
    end
    o.new_ax = clamp32(r[0]);
    o.new_ay = clamp32(r[1]);
    o.new_vax = clamp32(r[2]);
    o.new_vay = clamp32(r[3]);
    o.new_bx = clamp32(r[4]);
    o.new_by = clamp32(r[5]);
    o.new_vbx = clamp32(r[6]);
    o.new_vby = clamp32(r[7]);
    o.coincident = 1'b0;
    return o;
  endfunction

  function automatic cpcr_pair_t make_pair(input int ax, input int ay, input int vax,
                                           input int vay, input int bx, input int by,
                                           input int vbx, input int vby,
                                           input logic [31:0] rs, input logic [31:0] ma,
                                           input logic [31:0] mb, input logic [1:0] fl);
    cpcr_pair_t p;
    p.pos_ax = ax; p.pos_ay = ay; p.vel_ax = vax; p.vel_ay = vay;
    p.pos_bx = bx; p.pos_by = by; p.vel_bx = vbx; p.vel_by = vby;
    p.radius_sum = rs; p.mass_a = ma; p.mass_b = mb; p.fixed_flags = fl;
    return p;
  endfunction

  function automatic int span(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic cpcr_pair_t random_pair();
    cpcr_pair_t p;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
      if (p.mass_a == 0) p.mass_a = 1;
      if (p.mass_b == 0) p.mass_b = 1;
    end else begin
      p = make_pair(span(1 << 20), span(1 << 20), span(1 << 20), span(1 << 20), 0, 0,
                    span(1 << 20), span(1 << 20), $urandom_range(0, 1 << 19),
                    $urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20),
                    ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : FLAGS_NONE);
      p.pos_bx = p.pos_ax + span(1 << 18);
      p.pos_by = p.pos_ay + span(1 << 18);
    end
    if (kind == 2) begin
      p.pos_bx = p.pos_ax;
      p.pos_by = p.pos_ay;
    end
    return p;
  endfunction

  task automatic offer_pair(input cpcr_pair_t p, input bit typed, input cpcr_res_t want);
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      pair_valid = 1'b0;
      @(negedge clk);
    end
    pair_valid = 1'b1;
    pair = p;
    do @(posedge clk); while (pair_stall);
    pending_results.push_back(typed ? want : resolve_pair(p));
    @(negedge clk);
  endtask

  task automatic drain_results();
    pair_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0d actual %0d", name, $signed(want), $signed(got));
      failures++;
    end
  endtask

  always @(posedge clk) begin
    cpcr_res_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((pair_valid && !pair_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("circle_pair_collision_resolve_core_test failed");
        $finish;
      end
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word");
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("new_ax", want.new_ax, res.new_ax);
          check_field("new_ay", want.new_ay, res.new_ay);
          check_field("new_vax", want.new_vax, res.new_vax);
          check_field("new_vay", want.new_vay, res.new_vay);
          check_field("new_bx", want.new_bx, res.new_bx);
          check_field("new_by", want.new_by, res.new_by);
          check_field("new_vbx", want.new_vbx, res.new_vbx);
          check_field("new_vby", want.new_vby, res.new_vby);
          check_field("coincident", 32'(want.coincident), 32'(res.coincident));
        end
      end
    end
  end

  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        res_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end
      res_stall = (recv_pct != 0) && ($urandom_range(0, 99) < recv_pct);
    end
  end

  initial begin
    pair_row_t rows[$];
    pair_row_t row;
    cpcr_pair_t p;
    cpcr_res_t none;
    none = '0;
    failures = 0;
    long_hold = 1'b0;
    send_pct = 0;
    recv_pct = 0;
    rst = 1'b1;
    pair_valid = 1'b0;
    pair = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    p = '0;
    rows.push_back('{p, 1'b1, passthrough(p, 1'b1)});
    p = make_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                  32'hffffffff, 32'hffffffff, 32'hffffffff, FLAGS_NONE);
    rows.push_back('{p, 1'b1, passthrough(p, 1'b1)});
    p = make_pair(0, 0, 65536, 0, 131072, 0, -65536, 0, 65536, 65536, 65536, FLAGS_BOTH);
    rows.push_back('{p, 1'b1, passthrough(p, 1'b0)});
    p = make_pair(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  0, 1, 1, FLAGS_BOTH);
    rows.push_back('{p, 1'b1, passthrough(p, 1'b0)});
    p = make_pair(0, 0, 65536, 0, 65536, 0, -65536, 0, 131072, 65536, 65536, FLAGS_NONE);
    rows.push_back('{p, 1'b0, none});
    p = make_pair(0, 0, 65536, 0, 65536, 0, -65536, 0, 131072, 65536, 65536, 2'b01);
    rows.push_back('{p, 1'b0, none});
    p = make_pair(0, 0, 65536, 0, 65536, 0, -65536, 0, 131072, 65536, 65536, 2'b10);
    rows.push_back('{p, 1'b0, none});
    p = make_pair(0, 0, 0, 65536, 0, 655360, 0, 0, 65536, 65536, 65536, FLAGS_NONE);
    rows.push_back('{p, 1'b0, none});
    p = make_pair(32'h80000000, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0,
                  32'h80000000, 32'h7fffffff, 0, 32'hffffffff, 1, FLAGS_NONE);
    rows.push_back('{p, 1'b0, none});
    p = make_pair(32'h80000000, 32'h80000000, 0, 0, 32'h7fffffff, 32'h7fffffff,
                  0, 0, 32'hffffffff, 1, 32'hffffffff, FLAGS_NONE);
    rows.push_back('{p, 1'b0, none});
    p = make_pair(100, -300, 32'h7fffffff, 32'h7fffffff, 400, 100,
                  32'h80000000, 32'h80000000, 32'hffffffff, 1, 1, 2'b01);
    rows.push_back('{p, 1'b0, none});
    p = make_pair(-65536, 65536, 12345, -54321, 65536, -65536, -777, 999,
                  32'hffffffff, 32'hffffffff, 32'hffffffff, 2'b10);
    rows.push_back('{p, 1'b0, none});
    p = make_pair(0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 1, FLAGS_NONE);
    rows.push_back('{p, 1'b0, none});

    foreach (rows[i]) begin
      row = rows[i];
      offer_pair(row.pair, row.typed, row.want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0) begin
        send_pct = 28;
        recv_pct = 70;
      end else if (n == RANDOM_ITEMS / 3) begin
        drain_results();
        send_pct = 70;
        recv_pct = 28;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        drain_results();
        send_pct = 0;
        recv_pct = 0;
        long_hold = 1'b1;
      end else if (n == 5 * RANDOM_ITEMS / 6) begin
        send_pct = 0;
        recv_pct = 0;
      end
      offer_pair(random_pair(), 1'b0, none);
    end
    drain_results();
    repeat (150) @(negedge clk);
    if (failures == 0) begin
      $display("circle_pair_collision_resolve_core_test passed");
    end else begin
      $display("circle_pair_collision_resolve_core_test failed");
    end
    $finish;
  end

endmodule
